[src/mssc_pkg.sv]
// ----------------------------------------------------------------------------
// mssc_pkg
// Shared types and constants for the multiset subset check core.
// ----------------------------------------------------------------------------
package mssc_pkg;

  localparam int DEF_MAX_ITEMS  = 64;
  localparam int DEF_VALUE_BITS = 32;

  // request function codes
  typedef enum logic [1:0] {
    FN_MAIN  = 2'd0,
    FN_CAND  = 2'd1,
    FN_CHECK = 2'd2
  } func_t;

  // controller states
  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_MERGE = 1'b1
  } state_t;

  // per-chain command: sorted insert of the broadcast value, or shift toward the head
  typedef struct packed {
    logic ins;
    logic shift;
  } chain_ctl_t;

endpackage

[src/mssc_cell.sv]
// ----------------------------------------------------------------------------
// mssc_cell
// One slot of a sorted chain: holds an element, takes part in sorted insert
// and shifts toward the head during the merge walk.
// ----------------------------------------------------------------------------
module mssc_cell #(
  parameter int VALUE_BITS = mssc_pkg::DEF_VALUE_BITS
) (
  input  logic                          clk,
  input  mssc_pkg::chain_ctl_t          ctl,
  input  logic                          occ,
  input  logic signed [VALUE_BITS-1:0]  ins_value,
  input  logic signed [VALUE_BITS-1:0]  prev_val,
  input  logic                          prev_keep,
  input  logic signed [VALUE_BITS-1:0]  next_val,
  output logic signed [VALUE_BITS-1:0]  val,
  output logic                          keep
);
  import mssc_pkg::*;

  logic signed [VALUE_BITS-1:0] val_r;
  logic signed [VALUE_BITS-1:0] val_nxt;

  // keep: this slot is occupied and does not exceed the new element
  assign keep = occ && (val_r <= ins_value);
  assign val  = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins) begin
      if (keep) begin
        val_nxt = val_r;
      end else if (prev_keep) begin
        val_nxt = ins_value;
      end else begin
        val_nxt = prev_val;
      end
    end else if (ctl.shift) begin
      val_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

[src/mssc_chain.sv]
// ----------------------------------------------------------------------------
// mssc_chain
// Row of cells holding one set in ascending order, smallest at the head.
// ----------------------------------------------------------------------------
module mssc_chain #(
  parameter int MAX_ITEMS  = mssc_pkg::DEF_MAX_ITEMS,
  parameter int VALUE_BITS = mssc_pkg::DEF_VALUE_BITS,
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1)
) (
  input  logic                          clk,
  input  mssc_pkg::chain_ctl_t          ctl,
  input  logic        [CNT_W-1:0]       count,
  input  logic signed [VALUE_BITS-1:0]  ins_value,
  output logic signed [VALUE_BITS-1:0]  head
);
  import mssc_pkg::*;

  logic signed [VALUE_BITS-1:0] vals  [MAX_ITEMS];
  logic                         keeps [MAX_ITEMS];

  genvar i;
  generate
    for (i = 0; i < MAX_ITEMS; i++) begin : g_cell
      logic signed [VALUE_BITS-1:0] pv;
      logic                         pk;
      logic signed [VALUE_BITS-1:0] nv;
      logic                         occ;

      assign occ = CNT_W'(i) < count;
      if (i == 0) begin : g_first
        assign pv = ins_value;
        assign pk = 1'b1;
      end else begin : g_mid
        assign pv = vals[i-1];
        assign pk = keeps[i-1];
      end
      if (i == MAX_ITEMS - 1) begin : g_last
        assign nv = vals[i];
      end else begin : g_inner
        assign nv = vals[i+1];
      end

      mssc_cell #(
        .VALUE_BITS (VALUE_BITS)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .occ       (occ),
        .ins_value (ins_value),
        .prev_val  (pv),
        .prev_keep (pk),
        .next_val  (nv),
        .val       (vals[i]),
        .keep      (keeps[i])
      );
    end
  endgenerate

  assign head = vals[0];

endmodule

[src/multiset_subset_check_core.sv]
// ----------------------------------------------------------------------------
// multiset_subset_check_core
// Loads a main and a candidate multiset and checks containment on request.
// ----------------------------------------------------------------------------
// A load request (main or candidate) keeps busy low, so loads may be
// issued back to back: each one is inserted in sorted position into its
// chain of cells as it is accepted. A check request whose candidate is
// larger than the main set answers at once; otherwise busy rises and the
// merge walk retires one main-chain head per cycle until it decides. The
// result strobe out_valid comes in the cycle after the walk decides and
// lasts one cycle; the receiver cannot stall it, so sample it when it
// appears. Loads beyond MAX_ITEMS are dropped and reported in out_overflow
// of the next check, which also clears both sets.
// ----------------------------------------------------------------------------
module multiset_subset_check_core #(
  parameter int MAX_ITEMS  = mssc_pkg::DEF_MAX_ITEMS,
  parameter int VALUE_BITS = mssc_pkg::DEF_VALUE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic        [1:0]             in_func,
  input  logic signed [VALUE_BITS-1:0]  in_value,
  output logic                          out_valid,
  output logic                          out_is_subset,
  output logic                          out_overflow
);
  import mssc_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ITEMS);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] main_cnt_r, main_cnt_nxt;
  logic [CNT_W-1:0] cand_cnt_r, cand_cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r, out_is_subset_r, out_overflow_r;

  chain_ctl_t main_ctl, cand_ctl;
  logic signed [VALUE_BITS-1:0] main_head, cand_head;

  logic accept;
  logic drop;
  logic done;
  logic done_ok;
  logic go_merge;

  assign busy   = (state_r == ST_MERGE);
  assign accept = start && !busy;

  // hold both sets in sorted chains
  mssc_chain #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_main (
    .clk       (clk),
    .ctl       (main_ctl),
    .count     (main_cnt_r),
    .ins_value (in_value),
    .head      (main_head)
  );

  mssc_chain #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_cand (
    .clk       (clk),
    .ctl       (cand_ctl),
    .count     (cand_cnt_r),
    .ins_value (in_value),
    .head      (cand_head)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (go_merge) begin
          state_nxt = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // chain commands and the verdict
  always_comb begin
    main_ctl = '0;
    cand_ctl = '0;
    drop     = 1'b0;
    done     = 1'b0;
    done_ok  = 1'b0;
    go_merge = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_func)
            FN_MAIN: begin
              if (main_cnt_r == CNT_FULL) begin
                drop = 1'b1;
              end else begin
                main_ctl.ins = 1'b1;
              end
            end
            FN_CAND: begin
              if (cand_cnt_r == CNT_FULL) begin
                drop = 1'b1;
              end else begin
                cand_ctl.ins = 1'b1;
              end
            end
            FN_CHECK: begin
              // a larger candidate cannot fit: answer at once
              if (main_cnt_r < cand_cnt_r) begin
                done = 1'b1;
              end else begin
                go_merge = 1'b1;
              end
            end
            default: ;  // unused code: drop the request silently
          endcase
        end
      end
      ST_MERGE: begin
        if (cand_cnt_r == '0) begin
          // every candidate element matched
          done    = 1'b1;
          done_ok = 1'b1;
        end else if (main_cnt_r == '0) begin
          done = 1'b1;
        end else if (main_head < cand_head) begin
          // advance past a main element with no partner
          main_ctl.shift = 1'b1;
        end else if (main_head == cand_head) begin
          main_ctl.shift = 1'b1;
          cand_ctl.shift = 1'b1;
        end else begin
          // candidate head has no partner left
          done = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // counts and overflow flag
  always_comb begin
    main_cnt_nxt = main_cnt_r;
    cand_cnt_nxt = cand_cnt_r;
    ovf_nxt      = ovf_r | drop;
    if (done) begin
      main_cnt_nxt = '0;
      cand_cnt_nxt = '0;
      ovf_nxt      = 1'b0;
    end else begin
      if (main_ctl.ins) begin
        main_cnt_nxt = main_cnt_r + CNT_W'(1);
      end else if (main_ctl.shift) begin
        main_cnt_nxt = main_cnt_r - CNT_W'(1);
      end
      if (cand_ctl.ins) begin
        cand_cnt_nxt = cand_cnt_r + CNT_W'(1);
      end else if (cand_ctl.shift) begin
        cand_cnt_nxt = cand_cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      main_cnt_r  <= '0;
      cand_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      main_cnt_r  <= main_cnt_nxt;
      cand_cnt_r  <= cand_cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= done;
    end
  end

  // result payload, captured with the verdict
  always_ff @(posedge clk) begin
    if (done) begin
      out_is_subset_r <= done_ok;
      out_overflow_r  <= ovf_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_is_subset = out_is_subset_r;
  assign out_overflow  = out_overflow_r;

  // both sets are empty whenever a result is shown
  a_cleared_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (main_cnt_r == '0) && (cand_cnt_r == '0))
    else $error("sets not cleared with result");

  // the merge walk is entered only from a check request
  a_merge_from_check: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start) && ($past(in_func) == FN_CHECK))
    else $error("merge started without check request");

  // counts never pass capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (main_cnt_r <= CNT_FULL) && (cand_cnt_r <= CNT_FULL))
    else $error("set count beyond capacity");

  // a result follows the end of every merge walk
  a_merge_answers: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("merge ended without result");

endmodule
